### rtl/core/srl_pkg.sv
// Shared types and constants for the stereo linear resampler.
`default_nettype none

package srl_pkg;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned STEP_W      = 19;
  localparam int unsigned PHASE_W     = 20;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned MAX_RESULTS = 64;

  localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(65536);
  localparam logic [PHASE_W-1:0] ONE_Q16    = PHASE_W'(65536);

  // One input word: a stereo frame.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] in_left;
    logic signed [SAMPLE_W-1:0] in_right;
  } in_frame_t;

  // One output word: an interpolated stereo frame.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic                       last_of_run;
  } out_frame_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cfg_write;
    logic load_frame;
    logic mul;
    logic load_out;
    logic cap;
    logic load_pass;
    logic finalize;
  } srl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pass;
    logic phase_ge_one;
    logic last;
  } srl_sts_t;

endpackage

`default_nettype wire

### rtl/core/stereo_linear_resampler_q16.sv
// Top level of the stereo linear-interpolation resampler with a Q16 phase.
// The first output word of a frame is captured in the frame register on acceptance, its
// product is registered in the decide state and the word in the load state; a pass-through
// word goes from the frame register to the output register in the decide state. Outputs
// alternate between the load and present states of the controller, the present state holds
// while the sink stalls, and no new frame is taken until every output of the last is taken.
// Reset: step returns to 1.0 (pass through), phase and history clear to zero.
`default_nettype none

module stereo_linear_resampler_q16 #(
  parameter int unsigned MaxResults = srl_pkg::MAX_RESULTS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [18:0]          cfg_data_i,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire srl_pkg::in_frame_t   in_data_i,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output srl_pkg::out_frame_t       out_data_o
);
  import srl_pkg::*;

  srl_cmd_t cmd;
  srl_sts_t sts;
  logic     idle;

  srl_controller #(
    .MaxResults(MaxResults)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .cfg_valid_i (cfg_valid),
    .out_stall_i (out_stall),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .idle_o      (idle),
    .out_valid_o (out_valid)
  );

  srl_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

  assign in_stall  = !idle;
  assign cfg_ready = idle;

  // A word is taken only when no output is pending.
  a_no_accept_with_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> in_stall)
    else $error("input accepted while an output is pending");

  // A word that is not the last of its run is followed by more work for the same frame.
  a_run_continues : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_stall && !out_data_o.last_of_run) |=> in_stall)
    else $error("input accepted in the middle of a run");

  // Configuration is never taken while a frame is in flight.
  a_cfg_only_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready |-> !out_valid && !in_stall)
    else $error("configuration ready while busy");

endmodule

`default_nettype wire

### rtl/core/srl_datapath.sv
// Datapath of the resampler: step, phase, history, multipliers and output register.
`default_nettype none

module srl_datapath (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire srl_pkg::srl_cmd_t     cmd_i,
  input  wire logic [18:0]           cfg_data_i,
  input  wire srl_pkg::in_frame_t    in_data_i,
  output srl_pkg::srl_sts_t          sts_o,
  output srl_pkg::out_frame_t        out_data_o
);
  import srl_pkg::*;

  logic [STEP_W-1:0]          step_q;
  logic [PHASE_W-1:0]         phase_q, phase_d;
  logic signed [SAMPLE_W-1:0] prev_l_q, prev_r_q;
  in_frame_t                  frame_q;
  logic signed [33:0]         prod_l_q, prod_r_q, prod_l_d, prod_r_d;
  out_frame_t                 out_q;

  logic signed [SAMPLE_W:0]   diff_l, diff_r;
  logic signed [FRAC_W:0]     frac_s;
  logic signed [17:0]         sum_l, sum_r;
  logic [PHASE_W:0]           phase_sum;

  // Difference to the previous frame times the phase fraction.
  assign diff_l   = {frame_q.in_left[SAMPLE_W-1], frame_q.in_left}
                  - {prev_l_q[SAMPLE_W-1], prev_l_q};
  assign diff_r   = {frame_q.in_right[SAMPLE_W-1], frame_q.in_right}
                  - {prev_r_q[SAMPLE_W-1], prev_r_q};
  assign frac_s   = $signed({1'b0, phase_q[FRAC_W-1:0]});
  assign prod_l_d = 34'(diff_l * frac_s);
  assign prod_r_d = 34'(diff_r * frac_s);

  // Arithmetic shift gives the floor of the scaled product.
  assign sum_l = {{2{prev_l_q[SAMPLE_W-1]}}, prev_l_q} + prod_l_q[33:16];
  assign sum_r = {{2{prev_r_q[SAMPLE_W-1]}}, prev_r_q} + prod_r_q[33:16];

  assign phase_sum = {1'b0, phase_q} + {2'b00, step_q};

  // Drop one whole input period, clamping a phase that never reached one.
  always_comb begin
    if (phase_q >= ONE_Q16) begin
      phase_d = phase_q - ONE_Q16;
    end else begin
      phase_d = '0;
    end
  end

  // Control state: step register, phase and history.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= STEP_RESET;
      phase_q  <= '0;
      prev_l_q <= '0;
      prev_r_q <= '0;
    end else if (cmd_i.cfg_write) begin
      step_q   <= cfg_data_i;
      phase_q  <= '0;
      prev_l_q <= '0;
      prev_r_q <= '0;
    end else if (cmd_i.load_out) begin
      phase_q <= phase_sum[PHASE_W-1:0];
    end else if (cmd_i.finalize) begin
      phase_q  <= phase_d;
      prev_l_q <= frame_q.in_left;
      prev_r_q <= frame_q.in_right;
    end
  end

  // Payload registers: captured frame, products and output word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_frame) begin
      frame_q <= in_data_i;
    end
    if (cmd_i.mul) begin
      prod_l_q <= prod_l_d;
      prod_r_q <= prod_r_d;
    end
    if (cmd_i.load_pass) begin
      out_q.out_left    <= frame_q.in_left;
      out_q.out_right   <= frame_q.in_right;
      out_q.last_of_run <= 1'b1;
    end else if (cmd_i.load_out) begin
      out_q.out_left    <= sum_l[SAMPLE_W-1:0];
      out_q.out_right   <= sum_r[SAMPLE_W-1:0];
      out_q.last_of_run <= (phase_sum >= {1'b0, ONE_Q16}) || cmd_i.cap;
    end
  end

  assign sts_o.pass         = (step_q == STEP_RESET);
  assign sts_o.phase_ge_one = (phase_q >= ONE_Q16);
  assign sts_o.last         = out_q.last_of_run;
  assign out_data_o         = out_q;

endmodule

`default_nettype wire

### rtl/core/srl_controller.sv
// Controller state machine of the resampler: sequences each input frame's outputs.
`default_nettype none

module srl_controller #(
  parameter int unsigned MaxResults = srl_pkg::MAX_RESULTS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              cfg_valid_i,
  input  wire logic              out_stall_i,
  input  wire srl_pkg::srl_sts_t sts_i,
  output srl_pkg::srl_cmd_t      cmd_o,
  output logic                   idle_o,
  output logic                   out_valid_o
);
  import srl_pkg::*;

  localparam int unsigned CntW = $clog2(MaxResults);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_LOAD,
    S_OUT,
    S_PASS
  } state_e;

  state_e            state_q;
  logic [CntW-1:0]   cnt_q;
  logic              valid_q;
  logic              cap;

  assign cap = (cnt_q == CntW'(MaxResults - 1));

  // Commands decoded from the state.
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.cfg_write  = cfg_valid_i;
        cmd_o.load_frame = in_valid_i;
      end
      S_DECIDE: begin
        if (sts_i.pass) begin
          cmd_o.load_pass = 1'b1;
        end else if (sts_i.phase_ge_one) begin
          cmd_o.finalize = 1'b1;
        end else begin
          cmd_o.mul = 1'b1;
        end
      end
      S_LOAD: begin
        cmd_o.load_out = 1'b1;
        cmd_o.cap      = cap;
      end
      S_OUT: begin
        // Phase is already advanced, so the next product is formed here.
        cmd_o.mul      = 1'b1;
        cmd_o.finalize = !out_stall_i && sts_i.last;
      end
      S_PASS: begin
        cmd_o = '0;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // State, output count and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          cnt_q <= '0;
          if (sts_i.pass) begin
            state_q <= S_PASS;
            valid_q <= 1'b1;
          end else if (sts_i.phase_ge_one) begin
            state_q <= S_IDLE;
          end else begin
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          cnt_q   <= cnt_q + 1'b1;
          state_q <= S_OUT;
          valid_q <= 1'b1;
        end
        S_OUT: begin
          if (!out_stall_i) begin
            valid_q <= 1'b0;
            state_q <= sts_i.last ? S_IDLE : S_LOAD;
          end
        end
        S_PASS: begin
          if (!out_stall_i) begin
            valid_q <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
          valid_q <= 1'b0;
        end
      endcase
    end
  end

  assign idle_o      = (state_q == S_IDLE);
  assign out_valid_o = valid_q;

endmodule

`default_nettype wire

### sim/tb.sv
// Self-checking testbench for the stereo linear resampler, with its own predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srl_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [18:0] cfg_data_i;
  logic        in_valid;
  logic        in_stall;
  in_frame_t   in_data_i;
  logic        out_valid;
  logic        out_stall;
  out_frame_t  out_data_o;

  // Predictor state: the step register, the Q16 phase and the previous frame.
  logic [STEP_W-1:0]          step_reg;
  logic [PHASE_W-1:0]         phase_acc;
  logic signed [SAMPLE_W-1:0] hist_left;
  logic signed [SAMPLE_W-1:0] hist_right;

  // Output frames predicted but not yet seen, oldest first.
  out_frame_t frames_due[$];

  int  mismatches = 0;
  int  frames_taken = 0;
  int  frames_noted = 0;
  int  sink_gap = 0;
  bit  gaps_on = 1'b0;
  bit  stalls_on = 1'b0;

  stereo_linear_resampler_q16 uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data_i (cfg_data_i),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data_i  (in_data_i),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data_o (out_data_o)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Safety net in case the block hangs.
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Interpolate between two samples: a + floor((b - a) * frac / 65536).
  function automatic logic signed [SAMPLE_W-1:0] interp_sample(
      input logic signed [SAMPLE_W-1:0] a,
      input logic signed [SAMPLE_W-1:0] b,
      input logic [FRAC_W-1:0]          frac);
    longint diff;
    longint prod;
    longint sum;
    diff = longint'(b) - longint'(a);
    prod = diff * longint'(frac);
    sum  = longint'(a) + (prod >>> 16);
    return sum[SAMPLE_W-1:0];
  endfunction

  // Work out every output frame that one input word causes.
  task automatic predict_frame(input in_frame_t f);
    out_frame_t         o;
    logic [PHASE_W-1:0] nxt;
    int                 n;
    n = 0;
    if (step_reg == STEP_RESET) begin
      o.out_left    = f.in_left;
      o.out_right   = f.in_right;
      o.last_of_run = 1'b1;
      frames_due.push_back(o);
      return;
    end
    while (phase_acc < ONE_Q16 && n < int'(MAX_RESULTS)) begin
      nxt           = phase_acc + PHASE_W'(step_reg);
      o.out_left    = interp_sample(hist_left, f.in_left, phase_acc[FRAC_W-1:0]);
      o.out_right   = interp_sample(hist_right, f.in_right, phase_acc[FRAC_W-1:0]);
      o.last_of_run = (nxt >= ONE_Q16) || (n == int'(MAX_RESULTS) - 1);
      frames_due.push_back(o);
      phase_acc = nxt;
      n++;
    end
    // A step too small to reach 1.0 in 64 outputs leaves the phase at zero.
    phase_acc  = (phase_acc >= ONE_Q16) ? phase_acc - ONE_Q16 : '0;
    hist_left  = f.in_left;
    hist_right = f.in_right;
  endtask

  // Send one word; valid stays high until the next word or an explicit release.
  task automatic push_frame(input logic signed [SAMPLE_W-1:0] l,
                            input logic signed [SAMPLE_W-1:0] r);
    in_frame_t f;
    int        gap;
    f.in_left  = l;
    f.in_right = r;
    gap = gaps_on ? $urandom_range(0, 5) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    predict_frame(f);
    in_data_i <= f;
    in_valid  <= 1'b1;
    do @(posedge clk_i); while (in_stall);
  endtask

  // Drop valid and wait until every predicted frame has come out.
  task automatic drain_frames();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
    // A frame with no output may still be in flight.
    repeat (8) @(posedge clk_i);
  endtask

  // Write the step register while the block is idle.
  task automatic write_step(input logic [STEP_W-1:0] v);
    drain_frames();
    @(negedge clk_i);
    cfg_data_i <= v;
    cfg_valid  <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    step_reg   = v;
    phase_acc  = '0;
    hist_left  = '0;
    hist_right = '0;
  endtask

  // Mostly random samples, with the extremes showing up often.
  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    logic signed [SAMPLE_W-1:0] s;
    case ($urandom_range(0, 7))
      0:       s = 16'sh8000;
      1:       s = 16'sh7FFF;
      2:       s = '0;
      3:       s = '1;
      default: s = SAMPLE_W'($urandom);
    endcase
    return s;
  endfunction

  // Check each accepted output word against the oldest prediction.
  always @(posedge clk_i) begin : check_outputs
    out_frame_t want;
    if (rst_ni && out_valid && !out_stall) begin
      frames_taken <= frames_taken + 1;
      if (frames_due.size() == 0) begin
        $display("%0t: unexpected word, expected none, got %0d %0d %0d", $time,
                 out_data_o.out_left, out_data_o.out_right, out_data_o.last_of_run);
        mismatches++;
      end else begin
        want = frames_due.pop_front();
        if (out_data_o.out_left !== want.out_left) begin
          $display("%0t: out_left mismatch, expected %0d, got %0d", $time,
                   want.out_left, out_data_o.out_left);
          mismatches++;
        end
        if (out_data_o.out_right !== want.out_right) begin
          $display("%0t: out_right mismatch, expected %0d, got %0d", $time,
                   want.out_right, out_data_o.out_right);
          mismatches++;
        end
        if (out_data_o.last_of_run !== want.last_of_run) begin
          $display("%0t: last_of_run mismatch, expected %0d, got %0d", $time,
                   want.last_of_run, out_data_o.last_of_run);
          mismatches++;
        end
      end
    end
  end

  // Sink back-pressure: a fresh stall length is drawn after each accepted word.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (frames_taken != frames_noted) begin
        frames_noted = frames_taken;
        sink_gap     = stalls_on ? $urandom_range(0, 5) : 0;
      end
      if (sink_gap > 0) begin
        out_stall <= 1'b1;
        if (out_valid) sink_gap--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // After reset the block passes frames through unchanged.
  task automatic test_pass_through();
    push_frame(16'sh8000, 16'sh7FFF);
    push_frame(16'sh7FFF, 16'sh8000);
    push_frame('0, '1);
    push_frame(16'sh1234, -16'sd4660);
    push_frame(16'sh5555, 16'shAAAA);
  endtask

  // Small steps: 64 outputs per word, and the clamp below 1024.
  task automatic test_fine_step();
    write_step(STEP_W'(1024));
    push_frame(16'sh7FFF, 16'sh8000);
    push_frame(16'sh8000, 16'sh7FFF);
    push_frame('0, '0);
    write_step('0);
    push_frame(16'sh7FFF, 16'sh8000);
    push_frame(16'sh8000, 16'sh7FFF);
    write_step(STEP_W'(700));
    push_frame(16'sh8000, 16'sh7FFF);
  endtask

  // Large steps: many words give no output at all.
  task automatic test_coarse_step();
    write_step('1);
    push_frame(16'sh7FFF, 16'sh8000);
    push_frame(16'sh8000, 16'sh7FFF);
    push_frame(16'sh0001, -16'sd1);
    push_frame(16'sh4000, 16'shC000);
    push_frame(16'sh7FFF, 16'sh7FFF);
    write_step(STEP_W'(98304));
    push_frame(16'sh8000, 16'sh7FFF);
    push_frame(16'sh7FFF, 16'sh8000);
    push_frame(16'sh0100, -16'sd256);
    // Writing the same step again must clear phase and history.
    write_step(STEP_W'(98304));
    push_frame(16'sh7FFF, 16'sh8000);
    push_frame(16'sh8000, 16'sh7FFF);
  endtask

  // Random steps and samples, with and without idling on either side.
  task automatic test_random_steps();
    logic [STEP_W-1:0] s;
    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 5))
        0:       s = STEP_RESET;
        1:       s = STEP_W'($urandom_range(1024, 8191));
        2:       s = STEP_W'($urandom_range(8192, 131071));
        3:       s = STEP_W'($urandom_range(131072, 524287));
        4:       s = STEP_W'($urandom_range(0, 1023));
        default: s = $urandom_range(0, 1) ? '1 : STEP_W'(1024);
      endcase
      write_step(s);
      gaps_on   = (ph != 0) && ($urandom_range(0, 3) != 0);
      stalls_on = (ph != 0) && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 18; i++) begin
        push_frame(rand_sample(), rand_sample());
      end
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data_i = '0;
    in_valid   = 1'b0;
    in_data_i  = '0;
    step_reg   = STEP_RESET;
    phase_acc  = '0;
    hist_left  = '0;
    hist_right = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    test_pass_through();
    test_fine_step();
    test_coarse_step();
    test_random_steps();

    drain_frames();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### stereo_linear_resampler_q16.f
rtl/core/srl_pkg.sv
rtl/core/srl_datapath.sv
rtl/core/srl_controller.sv
rtl/core/stereo_linear_resampler_q16.sv
sim/tb.sv
